// ----- src/two_gate_velocity_timer_defines.svh -----
// assertion macros used by the velocity timer checker
// no dependencies; included by the checker file
`ifndef TWO_GATE_VELOCITY_TIMER_DEFINES_SVH
`define TWO_GATE_VELOCITY_TIMER_DEFINES_SVH

// same-cycle implication under reset
`define TGVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define TGVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tgvt_pkg.sv -----
// shared types and constants of the two-gate velocity timer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tgvt_pkg;

  // field widths
  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_W     = 10;
  localparam int DIST_W      = 10;
  localparam int OFFSET_W    = 12;
  localparam int TIMEOUT_W   = 20;
  localparam int SPEED_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int SCALE_W     = 10;
  localparam int DVD_W       = DIST_W + SCALE_W;
  localparam int STEP_W      = $clog2(DVD_W);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  // millimetres per microsecond to metres per second
  localparam logic [SCALE_W-1:0] MM_TO_M_SCALE = 10'd1000;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DIRECTION     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REG_START     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REG_STOP      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REV_START     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REV_STOP      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DISTANCE      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT       = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_MEASURED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONPOS   = 2'd2;

  // register reset values
  localparam logic                 RST_DIRECTION = 1'b0;
  localparam logic [LEVEL_W-1:0]   RST_REG_START = 10'd277;
  localparam logic [LEVEL_W-1:0]   RST_REG_STOP  = 10'd220;
  localparam logic [LEVEL_W-1:0]   RST_REV_START = 10'd230;
  localparam logic [LEVEL_W-1:0]   RST_REV_STOP  = 10'd2;
  localparam logic [DIST_W-1:0]    RST_DISTANCE  = 10'd116;
  localparam logic [OFFSET_W-1:0]  RST_OFFSET    = 12'd120;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT   = 20'd500000;

  typedef struct packed {
    logic                 direction_mode;
    logic [LEVEL_W-1:0]   regular_start_level;
    logic [LEVEL_W-1:0]   regular_stop_level;
    logic [LEVEL_W-1:0]   reverse_start_level;
    logic [LEVEL_W-1:0]   reverse_stop_level;
    logic [DIST_W-1:0]    gate_distance_mm;
    logic [OFFSET_W-1:0]  offset_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } tgvt_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clear_count;
    logic count_en;
    logic div_start;
    logic div_step;
    logic load_timeout;
    logic load_nonpos;
    logic load_speed;
  } tgvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_hit;
    logic timeout_hit;
    logic stop_hit;
    logic nonpos;
    logic div_last;
    logic out_free;
  } tgvt_stat_t;

endpackage

// ----- src/two_gate_velocity_timer.sv -----
// tick input: one sample pair per cycle while waiting or timing and the result register is free
// timeout and non-positive results: m_axis_tvalid rises in the cycle after the tick that ends timing
// measured speed: m_axis_tvalid rises once the one-bit-per-cycle divider has run through the divide phase
// input stalls during the divide and while a result waits with m_axis_tready low
// rst_ni clears phase, counter and result valid; registers return to defaults
`timescale 1ns / 1ps

module two_gate_velocity_timer
  import tgvt_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // gate_a_sample[9:0], gate_b_sample[19:10]
  // stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // speed_value[15:0]
  output logic [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  tgvt_cfg_t          cfg;
  tgvt_cmd_t          cmd;
  tgvt_stat_t         stat;
  logic [SPEED_W-1:0] speed;

  // register file
  tgvt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // phase control
  tgvt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // counting and division
  tgvt_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s_data_i   (s_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_speed_o  (speed),
    .m_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'(speed);

endmodule

// ----- src/tgvt_cfg.sv -----
// configuration register file with apb-style access
// depends on tgvt_pkg
`timescale 1ns / 1ps

module tgvt_cfg
  import tgvt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output tgvt_cfg_t             cfg_o
);

  tgvt_cfg_t              cfg_q;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction_mode      <= RST_DIRECTION;
      cfg_q.regular_start_level <= RST_REG_START;
      cfg_q.regular_stop_level  <= RST_REG_STOP;
      cfg_q.reverse_start_level <= RST_REV_START;
      cfg_q.reverse_stop_level  <= RST_REV_STOP;
      cfg_q.gate_distance_mm    <= RST_DISTANCE;
      cfg_q.offset_ticks        <= RST_OFFSET;
      cfg_q.timeout_ticks       <= RST_TIMEOUT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIRECTION: cfg_q.direction_mode      <= pwdata[0];
        REG_REG_START: cfg_q.regular_start_level <= pwdata[LEVEL_W-1:0];
        REG_REG_STOP:  cfg_q.regular_stop_level  <= pwdata[LEVEL_W-1:0];
        REG_REV_START: cfg_q.reverse_start_level <= pwdata[LEVEL_W-1:0];
        REG_REV_STOP:  cfg_q.reverse_stop_level  <= pwdata[LEVEL_W-1:0];
        REG_DISTANCE:  cfg_q.gate_distance_mm    <= pwdata[DIST_W-1:0];
        REG_OFFSET:    cfg_q.offset_ticks        <= pwdata[OFFSET_W-1:0];
        REG_TIMEOUT:   cfg_q.timeout_ticks       <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_DIRECTION: prdata = APB_DATA_W'(cfg_q.direction_mode);
      REG_REG_START: prdata = APB_DATA_W'(cfg_q.regular_start_level);
      REG_REG_STOP:  prdata = APB_DATA_W'(cfg_q.regular_stop_level);
      REG_REV_START: prdata = APB_DATA_W'(cfg_q.reverse_start_level);
      REG_REV_STOP:  prdata = APB_DATA_W'(cfg_q.reverse_stop_level);
      REG_DISTANCE:  prdata = APB_DATA_W'(cfg_q.gate_distance_mm);
      REG_OFFSET:    prdata = APB_DATA_W'(cfg_q.offset_ticks);
      REG_TIMEOUT:   prdata = APB_DATA_W'(cfg_q.timeout_ticks);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/tgvt_ctrl.sv -----
// controller state machine: waiting, timing and divide phases
// depends on tgvt_pkg; drives tgvt_dp through command signals
`timescale 1ns / 1ps

module tgvt_ctrl
  import tgvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  tgvt_stat_t stat_i,
  output tgvt_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_WAIT   = 3'b001,
    ST_TIMING = 3'b010,
    ST_DIVIDE = 3'b100
  } tgvt_state_e;

  tgvt_state_e state_q, state_d;
  logic        accept;

  assign s_ready_o = ((state_q == ST_WAIT) || (state_q == ST_TIMING)) && stat_i.out_free;
  assign accept    = s_valid_i & s_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_WAIT: begin
        if (accept && stat_i.start_hit) begin
          cmd_o.clear_count = 1'b1;
          state_d           = ST_TIMING;
        end
      end
      ST_TIMING: begin
        if (accept) begin
          cmd_o.count_en = 1'b1;
          if (stat_i.timeout_hit) begin
            cmd_o.load_timeout = 1'b1;
            state_d            = ST_WAIT;
          end else if (stat_i.stop_hit) begin
            if (stat_i.nonpos) begin
              cmd_o.load_nonpos = 1'b1;
              state_d           = ST_WAIT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIVIDE;
            end
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          cmd_o.load_speed = 1'b1;
          state_d          = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/tgvt_dp.sv -----
// datapath: gate compare, tick counter, bit-serial divider, result register
// depends on tgvt_pkg; controlled by tgvt_ctrl
`timescale 1ns / 1ps

module tgvt_dp
  import tgvt_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tgvt_cfg_t              cfg_i,
  input  logic [IN_TDATA_W-1:0]  s_data_i,
  input  tgvt_cmd_t              cmd_i,
  output tgvt_stat_t             stat_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [SPEED_W-1:0]     m_speed_o,
  output logic [STATUS_W-1:0]    m_status_o
);

  localparam int CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [SAMPLE_W-1:0]   gate_a, gate_b, start_s, stop_s;
  logic [LEVEL_W-1:0]    start_lv, stop_lv;
  logic [COUNT_BITS-1:0] count_q, count_d, count_next, offset_ext, shot;

  logic [DVD_W-1:0]      dvd_q, dvd_d;
  logic [COUNT_BITS-1:0] dsr_q, dsr_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [COUNT_BITS:0]   rem_shift, rem_diff;
  logic                  fits;
  logic [DVD_W-1:0]      quot;
  logic [SPEED_W-1:0]    speed_sat;

  logic                  out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]    out_speed_q, out_speed_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;

  // sample and level selection by direction
  assign gate_a   = s_data_i[SAMPLE_W-1:0];
  assign gate_b   = s_data_i[2*SAMPLE_W-1:SAMPLE_W];
  assign start_s  = cfg_i.direction_mode ? gate_b : gate_a;
  assign stop_s   = cfg_i.direction_mode ? gate_a : gate_b;
  assign start_lv = cfg_i.direction_mode ? cfg_i.reverse_start_level
                                         : cfg_i.regular_start_level;
  assign stop_lv  = cfg_i.direction_mode ? cfg_i.reverse_stop_level
                                         : cfg_i.regular_stop_level;

  // saturating tick count and its checks
  assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  assign offset_ext = COUNT_BITS'(cfg_i.offset_ticks);
  assign shot       = count_next - offset_ext;

  assign stat_o.start_hit   = start_s >= start_lv;
  assign stat_o.stop_hit    = stop_s >= stop_lv;
  assign stat_o.timeout_hit = CMP_W'(count_next) > CMP_W'(cfg_i.timeout_ticks);
  assign stat_o.nonpos      = count_next <= offset_ext;
  assign stat_o.div_last    = step_q == STEP_W'(DVD_W - 1);
  assign stat_o.out_free    = !out_valid_q || m_ready_i;

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_count) begin
      count_d = '0;
    end else if (cmd_i.count_en) begin
      count_d = count_next;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr_q};
  assign fits      = rem_shift >= {1'b0, dsr_q};
  assign quot      = {dvd_q[DVD_W-2:0], fits};
  assign speed_sat = (|quot[DVD_W-1:SPEED_W]) ? '1 : quot[SPEED_W-1:0];

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (cmd_i.div_start) begin
      dvd_d  = DVD_W'(cfg_i.gate_distance_mm) * DVD_W'(MM_TO_M_SCALE);
      dsr_d  = shot;
      rem_d  = '0;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d  = quot;
      rem_d  = fits ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
      step_d = step_q + 1'b1;
    end
  end

  // result register
  always_comb begin
    out_speed_d  = out_speed_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    if (cmd_i.load_timeout) begin
      out_speed_d  = '0;
      out_status_d = STATUS_TIMEOUT;
      out_valid_d  = 1'b1;
    end else if (cmd_i.load_nonpos) begin
      out_speed_d  = '0;
      out_status_d = STATUS_NONPOS;
      out_valid_d  = 1'b1;
    end else if (cmd_i.load_speed) begin
      out_speed_d  = speed_sat;
      out_status_d = STATUS_MEASURED;
      out_valid_d  = 1'b1;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_speed_o  = out_speed_q;
  assign m_status_o = out_status_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    dsr_q        <= dsr_d;
    rem_q        <= rem_d;
    out_speed_q  <= out_speed_d;
    out_status_q <= out_status_d;
  end

endmodule

// ----- src/tgvt_checker.sv -----
// port-level checks of the velocity timer, bound to the top level
// depends on tgvt_pkg and two_gate_velocity_timer_defines.svh
`timescale 1ns / 1ps
`include "two_gate_velocity_timer_defines.svh"

module tgvt_checker
  import tgvt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]    m_axis_tuser
);

  // a stalled result holds its payload
  `TGVT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // error results carry zero speed
  `TGVT_ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STATUS_MEASURED), m_axis_tdata == '0, "error result with non-zero speed")

  // only defined status codes leave the block
  `TGVT_ASSERT_IMPLY(a_status_code, clk_i, rst_ni, m_axis_tvalid, (m_axis_tuser == STATUS_MEASURED) || (m_axis_tuser == STATUS_TIMEOUT) || (m_axis_tuser == STATUS_NONPOS), "undefined status code")

  // no new request taken while a result is stuck
  `TGVT_ASSERT_IMPLY(a_in_blocked, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input taken while result stalled")

endmodule

bind two_gate_velocity_timer tgvt_checker u_tgvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/testbench.sv -----
// self-checking testbench of the two-gate velocity timer
// depends on tgvt_pkg and two_gate_velocity_timer; a scoreboard class predicts every reading
// and plain tasks drive the tick stream and the apb port
`timescale 1ns / 1ps

module testbench;
  import tgvt_pkg::*;

  localparam int          COUNT_W     = 20;
  localparam int unsigned COUNT_TOP   = (1 << COUNT_W) - 1;
  localparam int unsigned LEVEL_TOP   = (1 << LEVEL_W) - 1;
  localparam int unsigned SETTLE      = 32;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEM_GOAL   = 730;
  localparam longint      CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [STATUS_W-1:0] status;
  } reading_t;

  // predicts the readings of the chronograph from the accepted ticks
  class chrono_scoreboard;
    tgvt_cfg_t   cfg;
    bit          timing;
    int unsigned ticks;
    reading_t    awaited[$];
    int unsigned mismatches, n_measured, n_timeout, n_nonpos;

    function new();
      cfg = '{RST_DIRECTION, RST_REG_START, RST_REG_STOP, RST_REV_START, RST_REV_STOP,
              RST_DISTANCE, RST_OFFSET, RST_TIMEOUT};
      timing = 1'b0;
      ticks = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_DIRECTION: cfg.direction_mode = value[0];
        REG_REG_START: cfg.regular_start_level = value[LEVEL_W-1:0];
        REG_REG_STOP:  cfg.regular_stop_level = value[LEVEL_W-1:0];
        REG_REV_START: cfg.reverse_start_level = value[LEVEL_W-1:0];
        REG_REV_STOP:  cfg.reverse_stop_level = value[LEVEL_W-1:0];
        REG_DISTANCE:  cfg.gate_distance_mm = value[DIST_W-1:0];
        REG_OFFSET:    cfg.offset_ticks = value[OFFSET_W-1:0];
        default:       cfg.timeout_ticks = value[TIMEOUT_W-1:0];
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_DIRECTION: return APB_DATA_W'(cfg.direction_mode);
        REG_REG_START: return APB_DATA_W'(cfg.regular_start_level);
        REG_REG_STOP:  return APB_DATA_W'(cfg.regular_stop_level);
        REG_REV_START: return APB_DATA_W'(cfg.reverse_start_level);
        REG_REV_STOP:  return APB_DATA_W'(cfg.reverse_stop_level);
        REG_DISTANCE:  return APB_DATA_W'(cfg.gate_distance_mm);
        REG_OFFSET:    return APB_DATA_W'(cfg.offset_ticks);
        default:       return APB_DATA_W'(cfg.timeout_ticks);
      endcase
    endfunction

    // one accepted tick request, may queue one reading
    function void note_tick(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W-1:0] start_s, stop_s, start_lv, stop_lv;
      longint unsigned     v;
      reading_t            r;
      start_s  = cfg.direction_mode ? b : a;
      stop_s   = cfg.direction_mode ? a : b;
      start_lv = cfg.direction_mode ? cfg.reverse_start_level : cfg.regular_start_level;
      stop_lv  = cfg.direction_mode ? cfg.reverse_stop_level : cfg.regular_stop_level;
      if (!timing) begin
        if (start_s >= start_lv) begin
          timing = 1'b1;
          ticks = 0;
        end
        return;
      end
      if (ticks < COUNT_TOP) ticks++;
      // timeout takes priority over a stop crossing on the same tick
      if (ticks > cfg.timeout_ticks) begin
        timing = 1'b0;
        r = '{speed: '0, status: STATUS_TIMEOUT};
        awaited.push_back(r);
        return;
      end
      if (stop_s >= stop_lv) begin
        timing = 1'b0;
        if (ticks <= cfg.offset_ticks) begin
          r = '{speed: '0, status: STATUS_NONPOS};
        end else begin
          v = (64'(cfg.gate_distance_mm) * 64'd1000) / 64'(ticks - cfg.offset_ticks);
          if (v > 64'hFFFF) v = 64'hFFFF;
          r = '{speed: v[SPEED_W-1:0], status: STATUS_MEASURED};
        end
        awaited.push_back(r);
      end
    endfunction

    // one accepted reading from the block
    function void check_reading(logic [SPEED_W-1:0] speed, logic [STATUS_W-1:0] status);
      reading_t r;
      if (awaited.size() == 0) begin
        $error("unexpected reading: speed_value %0d status %0d", speed, status);
        mismatches++;
        return;
      end
      r = awaited.pop_front();
      if (speed !== r.speed) begin
        $error("speed_value: expected %0d, actual %0d", r.speed, speed);
        mismatches++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        mismatches++;
      end
      case (r.status)
        STATUS_MEASURED: n_measured++;
        STATUS_TIMEOUT:  n_timeout++;
        default:         n_nonpos++;
      endcase
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // gate_a_sample[9:0], gate_b_sample[19:10]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // speed_value[15:0]
  logic [STATUS_W-1:0]    m_axis_tuser;   // status[1:0]
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  chrono_scoreboard chrono = new();
  bit               no_idle;
  bit               hold_req;
  int unsigned      ticks_sent;
  int unsigned      reg_mismatches;
  int unsigned      phase;
  longint           cycles;

  two_gate_velocity_timer #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // apb write then read back of one register; psel stays high for the next transfer
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    chrono.write_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== chrono.reg_value(idx)) begin
      $error("register %0d: expected %0h, actual %0h", idx, chrono.reg_value(idx), prdata);
      reg_mismatches++;
    end
  endtask

  // wait until every reading is in and the block has gone quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chrono.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input tgvt_cfg_t c);
    drain();
    reg_write(REG_DIRECTION, APB_DATA_W'(c.direction_mode));
    reg_write(REG_REG_START, APB_DATA_W'(c.regular_start_level));
    reg_write(REG_REG_STOP,  APB_DATA_W'(c.regular_stop_level));
    reg_write(REG_REV_START, APB_DATA_W'(c.reverse_start_level));
    reg_write(REG_REV_STOP,  APB_DATA_W'(c.reverse_stop_level));
    reg_write(REG_DISTANCE,  APB_DATA_W'(c.gate_distance_mm));
    reg_write(REG_OFFSET,    APB_DATA_W'(c.offset_ticks));
    reg_write(REG_TIMEOUT,   APB_DATA_W'(c.timeout_ticks));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one tick request, with a random gap in front unless no_idle is set
  task automatic send_tick(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(19, 0);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 2 * SAMPLE_W){1'b0}}, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    chrono.note_tick(a, b);
    ticks_sent++;
  endtask

  // tick given as start-gate and stop-gate samples of the current direction
  task automatic gated_tick(input logic rev, input logic [SAMPLE_W-1:0] start_s,
                            input logic [SAMPLE_W-1:0] stop_s);
    if (rev) begin
      send_tick(stop_s, start_s);
    end else begin
      send_tick(start_s, stop_s);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] below(input logic [SAMPLE_W-1:0] lv);
    return (lv == 0) ? '0 : SAMPLE_W'($urandom_range(lv - 1, 0));
  endfunction

  function automatic logic [SAMPLE_W-1:0] any_sample();
    return SAMPLE_W'($urandom_range(LEVEL_TOP, 0));
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return LEVEL_W'(LEVEL_TOP);
      default: return LEVEL_W'($urandom_range(LEVEL_TOP, 0));
    endcase
  endfunction

  function automatic tgvt_cfg_t random_cfg();
    tgvt_cfg_t c;
    c.direction_mode      = 1'($urandom_range(1, 0));
    c.regular_start_level = pick_level();
    c.regular_stop_level  = pick_level();
    c.reverse_start_level = pick_level();
    c.reverse_stop_level  = pick_level();
    case ($urandom_range(3, 0))
      0:       c.gate_distance_mm = DIST_W'(1);
      1:       c.gate_distance_mm = DIST_W'(1023);
      default: c.gate_distance_mm = DIST_W'($urandom_range(1023, 1));
    endcase
    case ($urandom_range(4, 0))
      0:       c.offset_ticks = '0;
      1:       c.offset_ticks = OFFSET_W'(4095);
      default: c.offset_ticks = OFFSET_W'($urandom_range(30, 0));
    endcase
    case ($urandom_range(5, 0))
      0:       c.timeout_ticks = TIMEOUT_W'(COUNT_TOP);
      1:       c.timeout_ticks = TIMEOUT_W'($urandom_range(COUNT_TOP, 41));
      default: c.timeout_ticks = TIMEOUT_W'($urandom_range(40, 1));
    endcase
    return c;
  endfunction

  // a well-formed shot: quiet ticks, start crossing, waiting ticks, stop crossing
  task automatic fire_shot();
    logic                rev;
    logic [SAMPLE_W-1:0] start_lv, stop_lv;
    int unsigned         len, off, tmo;
    rev      = chrono.cfg.direction_mode;
    start_lv = rev ? chrono.cfg.reverse_start_level : chrono.cfg.regular_start_level;
    stop_lv  = rev ? chrono.cfg.reverse_stop_level : chrono.cfg.regular_stop_level;
    off      = 32'(chrono.cfg.offset_ticks);
    tmo      = 32'(chrono.cfg.timeout_ticks);
    case ($urandom_range(2, 0))
      // aim for a measured speed
      0:       len = (off <= 40) ? $urandom_range(off + 15, off) : $urandom_range(20, 0);
      // aim at or under the offset
      1:       len = $urandom_range((off < 20) ? off : 20, 0);
      // aim around the timeout
      default: len = (tmo <= 40) ? $urandom_range(tmo + 1, tmo - 1) : $urandom_range(20, 0);
    endcase
    repeat ($urandom_range(2, 0)) gated_tick(rev, below(start_lv), any_sample());
    gated_tick(rev, SAMPLE_W'($urandom_range(LEVEL_TOP, start_lv)), any_sample());
    repeat (len) gated_tick(rev, any_sample(), below(stop_lv));
    gated_tick(rev, any_sample(), SAMPLE_W'($urandom_range(LEVEL_TOP, stop_lv)));
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = no_idle ? 0 : $urandom_range(19, 0);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      chrono.check_reading(m_axis_tdata, m_axis_tuser);
    end
  end

  // stimulus
  initial begin
    tgvt_cfg_t   c;
    int unsigned goal;
    cycles        <= 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset levels: start exactly at level, stop on the first tick under the offset
    send_tick(10'd277, 10'd0);
    send_tick(10'd0, 10'd220);
    send_tick(10'd276, 10'd1023);

    // top levels, widest gates, no offset, short timeout
    set_config('{1'b0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd1023, 12'd0, 20'd3});
    send_tick(10'd1022, 10'd1023);   // just under start level
    send_tick(10'd1023, 10'd0);      // start
    send_tick(10'd0, 10'd1023);      // one tick, speed saturates
    send_tick(10'd1023, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd1023);      // timeout wins over the stop crossing

    // reverse direction, narrowest gates, timeout at counter top
    set_config('{1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1, 12'd2, 20'hFFFFF});
    send_tick(10'd0, 10'd1023);      // start on gate b
    send_tick(10'd1023, 10'd0);      // stop within offset
    send_tick(10'd0, 10'd1023);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd1023, 10'd1023);   // measured
    send_tick(10'd1023, 10'd1023);   // start, left timing over the next write

    // direction flips while timing, largest offset, shortest timeout
    set_config('{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd512, 12'd4095, 20'd1});
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);
    send_tick(10'd0, 10'd0);

    // random phases
    phase = 0;
    while (ticks_sent < ITEM_GOAL && phase < 60) begin
      c = random_cfg();
      set_config(c);
      no_idle = (phase % 5 == 2);
      if (phase == 3) hold_req = 1'b1;
      goal = ticks_sent + 60;
      while (ticks_sent < goal) begin
        if ($urandom_range(4, 0) == 0) begin
          send_tick(any_sample(), any_sample());
        end else begin
          fire_shot();
        end
      end
      phase++;
    end

    drain();
    $display("covered %0d gate ticks over %0d random settings and the directed cases",
             ticks_sent, phase);
    $display("readings checked: %0d measured, %0d timeout, %0d non-positive",
             chrono.n_measured, chrono.n_timeout, chrono.n_nonpos);
    if (chrono.mismatches == 0 && reg_mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
